### sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define D3Q7_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define D3Q7_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/d3q7_pkg.sv
// Shared types and constants of the D3Q7 Poisson collision block.
package d3q7_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int RLX_W      = 18;
    localparam int INV_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_PERM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_NEUTRAL = 2'd2;

    localparam logic [RLX_W-1:0] RLX_RESET = 18'd65536;
    localparam logic [INV_W-1:0] INV_RESET = 32'd65536;

    typedef struct packed {
        logic [RLX_W-1:0] relax_rate;
        logic [INV_W-1:0] inv_permittivity;
        logic             force_neutral;
    } t_cfg;

endpackage

### sv/d3q7_cfg.sv
// Configuration register file of the D3Q7 Poisson collision block.
module d3q7_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [d3q7_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [d3q7_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output d3q7_pkg::t_cfg                   o_cfg
);
    import d3q7_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Drop bits above each register's width; ignore unknown indexes.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RELAX_RATE:    n_cfg.relax_rate       = i_cfg_wdata[RLX_W-1:0];
                CFG_INV_PERM:      n_cfg.inv_permittivity = i_cfg_wdata[INV_W-1:0];
                CFG_FORCE_NEUTRAL: n_cfg.force_neutral    = i_cfg_wdata[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.relax_rate       <= RLX_RESET;
            r_cfg.inv_permittivity <= INV_RESET;
            r_cfg.force_neutral    <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/d3q7_poisson_collision.sv
// Top level: D3Q7 lattice Boltzmann Poisson BGK collision pipeline.
//
// Usage:
//   One lattice site per beat. The input channel (i_in_valid / o_in_stall)
//   carries the seven incoming distributions, the site potential and the
//   charge density; the output channel (o_out_valid / i_out_stall) returns
//   the electric field, the seven relaxed distributions and the potential
//   sum. All values are signed fixed point with FRAC_BITS fraction bits and
//   saturate to DATA_WIDTH bits.
//   Pipeline: an accepted beat passes through four stages in order (input
//   register, multiplier stage, rounding stage, output register) and is
//   held in the output register until taken. Throughput: one site per
//   cycle while i_out_stall is low.
//   Stalls: when i_out_stall is high the output beat holds; bubbles inside
//   the pipe still close up, and o_in_stall rises only once every stage is
//   full. Nothing is dropped or repeated.
//   Configuration: write relax_rate, inv_permittivity and force_neutral
//   through i_cfg_we / i_cfg_idx / i_cfg_wdata while the pipe is empty.
//   Reset: synchronous, active low; empties the pipe and loads relax rate
//   1.0, inverse permittivity 1.0 and charge source enabled.
module d3q7_poisson_collision #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [d3q7_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [d3q7_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]     i_dist_rest,
    input  logic signed [DATA_WIDTH-1:0]     i_dist_xp,
    input  logic signed [DATA_WIDTH-1:0]     i_dist_xm,
    input  logic signed [DATA_WIDTH-1:0]     i_dist_yp,
    input  logic signed [DATA_WIDTH-1:0]     i_dist_ym,
    input  logic signed [DATA_WIDTH-1:0]     i_dist_zp,
    input  logic signed [DATA_WIDTH-1:0]     i_dist_zm,
    input  logic signed [DATA_WIDTH-1:0]     i_potential,
    input  logic signed [DATA_WIDTH-1:0]     i_charge_density,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [DATA_WIDTH-1:0]     o_field_x,
    output logic signed [DATA_WIDTH-1:0]     o_field_y,
    output logic signed [DATA_WIDTH-1:0]     o_field_z,
    output logic signed [DATA_WIDTH-1:0]     o_new_rest,
    output logic signed [DATA_WIDTH-1:0]     o_new_xp,
    output logic signed [DATA_WIDTH-1:0]     o_new_xm,
    output logic signed [DATA_WIDTH-1:0]     o_new_yp,
    output logic signed [DATA_WIDTH-1:0]     o_new_ym,
    output logic signed [DATA_WIDTH-1:0]     o_new_zp,
    output logic signed [DATA_WIDTH-1:0]     o_new_zm,
    output logic signed [DATA_WIDTH-1:0]     o_potential_sum
);
    import d3q7_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    // Product width: widest product is charge times {0, inv_permittivity}.
    localparam int PW  = DW + INV_W + 2;
    // Width of 1 - rlx: must hold 2^F and 2^F - (2^RLX_W - 1).
    localparam int OMW = (F + 2 > RLX_W + 2) ? F + 2 : RLX_W + 2;
    localparam int SW  = DW + 3;
    localparam logic signed [OMW-1:0] ONE_Q  = OMW'(1) <<< F;
    localparam logic signed [PW-1:0]  SAT_HI = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PW-1:0]  SAT_LO = ~SAT_HI;

    // Round to nearest, ties toward +infinity.
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                 input int s);
        logic signed [PW-1:0] half;
        half = PW'(1) <<< (s - 1);
        if (s == 0) return v;
        return (v + half) >>> s;
    endfunction

    // Clamp to the signed DW-bit range.
    function automatic logic signed [DW-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        c = v;
        if (v > SAT_HI) c = SAT_HI;
        else if (v < SAT_LO) c = SAT_LO;
        return c[DW-1:0];
    endfunction

    t_cfg w_cfg;

    d3q7_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // ---------------------------------------------------------------
    // Handshake: a stage loads when it is empty or the next one moves.
    // ---------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic w_adv1, w_adv2, w_adv3, w_adv4;

    assign w_adv4 = !r_out_valid || !i_out_stall;
    assign w_adv3 = !r_s3_valid  || w_adv4;
    assign w_adv2 = !r_s2_valid  || w_adv3;
    assign w_adv1 = !r_s1_valid  || w_adv2;

    assign o_in_stall  = !w_adv1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv1) r_s1_valid  <= i_in_valid;
            if (w_adv2) r_s2_valid  <= r_s1_valid;
            if (w_adv3) r_s3_valid  <= r_s2_valid;
            if (w_adv4) r_out_valid <= r_s3_valid;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: input register, plus the three opposite-pair differences.
    // ---------------------------------------------------------------
    logic signed [DW-1:0] n_s1_f [7];
    logic signed [DW-1:0] r_s1_f [7];
    logic signed [DW:0]   n_s1_d [3];
    logic signed [DW:0]   r_s1_d [3];
    logic signed [DW-1:0] r_s1_psi, r_s1_chg;

    always_comb begin
        n_s1_f[0] = i_dist_rest;
        n_s1_f[1] = i_dist_xp;
        n_s1_f[2] = i_dist_xm;
        n_s1_f[3] = i_dist_yp;
        n_s1_f[4] = i_dist_ym;
        n_s1_f[5] = i_dist_zp;
        n_s1_f[6] = i_dist_zm;
        for (int j = 0; j < 3; j++) begin
            n_s1_d[j] = (DW+1)'(n_s1_f[2*j+1]) - (DW+1)'(n_s1_f[2*j+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_f   <= n_s1_f;
            r_s1_d   <= n_s1_d;
            r_s1_psi <= i_potential;
            r_s1_chg <= i_charge_density;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: all multiplications, and the potential sum.
    // ---------------------------------------------------------------
    logic signed [OMW-1:0] w_one_m;
    logic signed [PW-1:0]  w_rlx, w_inv;
    logic signed [PW-1:0]  n_s2_pf [7];
    logic signed [PW-1:0]  r_s2_pf [7];
    logic signed [PW-1:0]  n_s2_pe [3];
    logic signed [PW-1:0]  r_s2_pe [3];
    logic signed [PW-1:0]  n_s2_prho, r_s2_prho;
    logic signed [PW-1:0]  n_s2_ppsi, r_s2_ppsi;
    logic signed [SW-1:0]  n_s2_sum, r_s2_sum;

    assign w_one_m = ONE_Q - $signed(OMW'(w_cfg.relax_rate));
    assign w_rlx   = $signed(PW'(w_cfg.relax_rate));
    assign w_inv   = $signed(PW'(w_cfg.inv_permittivity));

    always_comb begin
        for (int i = 0; i < 7; i++) begin
            n_s2_pf[i] = PW'(r_s1_f[i]) * PW'(w_one_m);
        end
        for (int j = 0; j < 3; j++) begin
            n_s2_pe[j] = PW'(r_s1_d[j]) * w_rlx;
        end
        n_s2_prho = PW'(r_s1_chg) * w_inv;
        n_s2_ppsi = PW'(r_s1_psi) * w_rlx;
        n_s2_sum  = '0;
        for (int i = 0; i < 7; i++) begin
            n_s2_sum = n_s2_sum + SW'(r_s1_f[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_pf   <= n_s2_pf;
            r_s2_pe   <= n_s2_pe;
            r_s2_prho <= n_s2_prho;
            r_s2_ppsi <= n_s2_ppsi;
            r_s2_sum  <= n_s2_sum;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: round the products, form the source term, finish the
    // field and the potential sum.
    // ---------------------------------------------------------------
    logic signed [PW-1:0] n_s3_part [7];
    logic signed [PW-1:0] r_s3_part [7];
    logic signed [PW-1:0] n_s3_src, r_s3_src;
    logic signed [PW-1:0] w_rho;
    logic signed [DW-1:0] n_s3_field [3];
    logic signed [DW-1:0] r_s3_field [3];
    logic signed [DW-1:0] n_s3_pot, r_s3_pot;

    always_comb begin
        for (int i = 0; i < 7; i++) begin
            n_s3_part[i] = rnd(r_s2_pf[i], F);
        end
        // Neutral mode drops the charge source entirely.
        w_rho    = w_cfg.force_neutral ? '0 : rnd(r_s2_prho, F);
        n_s3_src = rnd(r_s2_ppsi, F) + w_rho;
        // 4 * rlx * diff: shift two bits less than the fraction.
        for (int j = 0; j < 3; j++) begin
            n_s3_field[j] = sat(rnd(r_s2_pe[j], F - 2));
        end
        n_s3_pot = sat(PW'(r_s2_sum));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_s3_part  <= n_s3_part;
            r_s3_src   <= n_s3_src;
            r_s3_field <= n_s3_field;
            r_s3_pot   <= n_s3_pot;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: add the weighted source (1/4 rest, 1/8 moving), saturate,
    // and hold in the output register.
    // ---------------------------------------------------------------
    logic signed [DW-1:0] n_out_new [7];
    logic signed [DW-1:0] r_out_new [7];
    logic signed [DW-1:0] r_out_field [3];
    logic signed [DW-1:0] r_out_pot;

    always_comb begin
        n_out_new[0] = sat(r_s3_part[0] + rnd(r_s3_src, 2));
        for (int i = 1; i < 7; i++) begin
            n_out_new[i] = sat(r_s3_part[i] + rnd(r_s3_src, 3));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_out_new   <= n_out_new;
            r_out_field <= r_s3_field;
            r_out_pot   <= r_s3_pot;
        end
    end

    assign o_field_x       = r_out_field[0];
    assign o_field_y       = r_out_field[1];
    assign o_field_z       = r_out_field[2];
    assign o_new_rest      = r_out_new[0];
    assign o_new_xp        = r_out_new[1];
    assign o_new_xm        = r_out_new[2];
    assign o_new_yp        = r_out_new[3];
    assign o_new_ym        = r_out_new[4];
    assign o_new_zp        = r_out_new[5];
    assign o_new_zm        = r_out_new[6];
    assign o_potential_sum = r_out_pot;

endmodule

### sv/d3q7_checker.sv
// Port-level checker of the D3Q7 Poisson collision block, bound to the top.
`include "assert_macros.svh"

module d3q7_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic signed [DATA_WIDTH-1:0] o_new_rest,
    input logic signed [DATA_WIDTH-1:0] o_potential_sum
);

    // A stalled output beat stays and keeps its payload.
    `D3Q7_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_new_rest) && $stable(o_potential_sum), "stalled output beat changed")

    // The pipe leaves reset empty.
    `D3Q7_ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $rose(i_rst_n), !o_out_valid, "output valid right after reset")

    // With the output register free every stage moves, so input is taken.
    `D3Q7_ASSERT_SAME(a_no_stall_when_free, i_clk, i_rst_n, !o_out_valid, !o_in_stall, "input stalled while output register is empty")

    // An accepted beat reaches the output register if i_out_stall stays low while it passes the stages.
    `D3Q7_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_in_valid && !o_in_stall) ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall, o_out_valid, "accepted beat did not reach the output")

endmodule

bind d3q7_poisson_collision d3q7_checker #(.DATA_WIDTH(DATA_WIDTH)) u_d3q7_checker (.*);
